>>> rtl/band_onset_trail_scroller_core_assert.svh
// assertion macros shared by the band onset trail scroller rtl
`ifndef BAND_ONSET_TRAIL_SCROLLER_CORE_ASSERT_SVH
`define BAND_ONSET_TRAIL_SCROLLER_CORE_ASSERT_SVH

// same-cycle implication, checked on clk_i, off during reset
`define BOST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bost assertion failed");

// next-cycle implication, checked on clk_i, off during reset
`define BOST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bost assertion failed");

`endif

>>> rtl/bost_pkg.sv
// shared types, constants and arithmetic helpers of the trail scroller
package bost_pkg;

  localparam int unsigned ColumnsDef = 12;
  localparam int unsigned RowsDef    = 144;

  localparam logic [3:0] BAND_COUNT_RST = 4'd12;
  localparam logic [7:0] TRAIL_DECAY    = 8'd246;
  localparam logic [6:0] DT_CLAMP       = 7'd100;
  localparam logic [2:0] MAX_STEPS      = 3'd6;
  localparam logic [15:0] MAX_DECAY     = 16'd65208;
  localparam logic [15:0] MAX_FLOOR     = 16'd128;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    WS_ZERO  = 2'd0,
    WS_DECAY = 2'd1,
    WS_INJ   = 2'd2
  } wsrc_e;

  typedef struct packed {
    logic  re;
    logic  we;
    wsrc_e wsrc;
    logic  upd;
    logic  clr;
    logic  inj_clr;
  } ctrl_t;

  typedef struct packed {
    logic [7:0]  trail;
    logic [15:0] bmax;
  } chain_t;

  function automatic logic [7:0] sc8(input logic [7:0] v, input logic [7:0] s);
    logic [15:0] p;
    p = 16'(v) * (16'(s) + 16'd1);
    return p[15:8];
  endfunction

  function automatic logic [7:0] qadd8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] t;
    t = 9'(a) + 9'(b);
    return t[8] ? 8'hFF : t[7:0];
  endfunction

  function automatic logic [7:0] qsub8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : 8'd0;
  endfunction

  // floor(x / 255), exact for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

>>> rtl/bost_cell.sv
// one column cell: trail memory of the column plus that band's onset state
module bost_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned ROWS = bost_pkg::RowsDef,
  parameter int unsigned AW   = $clog2(ROWS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bost_pkg::ctrl_t  ctrl_i,
  input  logic [3:0]       sel_i,
  input  logic [AW-1:0]    ra_i,
  input  logic [AW-1:0]    wa_i,
  input  logic [7:0]       norm_i,
  input  logic [15:0]      m_i,
  input  logic [5:0]       bands_i,
  input  bost_pkg::chain_t chain_i,
  output bost_pkg::chain_t chain_o
);
  import bost_pkg::*;

  logic [7:0] mem [ROWS];
  logic [7:0] rdata_q;
  logic [7:0] wd;

  logic [15:0] bm_q, bm_d;
  logic [7:0]  prev_q, prev_d, gate_q, gate_d, inj_q, inj_d;
  logic [1:0]  cd_q, cd_d;

  logic       hit, onset;
  logic [1:0] cd_dec;
  logic [7:0] g1, g2, g3;

  always_comb begin
    unique case (ctrl_i.wsrc)
      WS_DECAY: wd = sc8(rdata_q, TRAIL_DECAY);
      WS_INJ:   wd = (6'(IDX) < bands_i) ? inj_q : 8'd0;
      default:  wd = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) mem[wa_i] <= wd;
    if (ctrl_i.re) rdata_q <= mem[ra_i];
  end

  assign hit = ctrl_i.upd && (int'(sel_i) == int'(IDX));

  always_comb begin
    cd_dec = (cd_q != 2'd0) ? (cd_q - 2'd1) : 2'd0;
    onset  = (cd_dec == 2'd0) && (norm_i > 8'd140) && (norm_i > prev_q)
             && ((norm_i - prev_q) > 8'd25);
    g1 = onset ? qadd8(gate_q, 8'd170 + div255(16'(norm_i) * 16'd80)) : gate_q;
    g2 = (norm_i > 8'd127) ? qadd8(g1, 8'd6 + div255(16'(norm_i) * 16'd20)) : g1;
    g3 = qsub8(g2, (norm_i > 8'd102) ? 8'd2 : 8'd10);

    bm_d = bm_q; prev_d = prev_q; gate_d = gate_q; inj_d = inj_q; cd_d = cd_q;
    if (ctrl_i.clr) begin
      bm_d = '0; prev_d = '0; gate_d = '0; inj_d = '0; cd_d = '0;
    end else if (hit) begin
      bm_d   = m_i;
      prev_d = norm_i;
      gate_d = g3;
      cd_d   = onset ? 2'd2 : cd_dec;
      inj_d  = (g3 != 8'd0) ? qadd8(norm_i, sc8(g3, 8'd40)) : 8'd0;
    end else if (ctrl_i.inj_clr) begin
      inj_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bm_q <= '0; prev_q <= '0; gate_q <= '0; inj_q <= '0; cd_q <= '0;
    end else begin
      bm_q <= bm_d; prev_q <= prev_d; gate_q <= gate_d; inj_q <= inj_d; cd_q <= cd_d;
    end
  end

  // selected cell puts its read word and band maximum on the chain
  assign chain_o = (int'(sel_i) == int'(IDX)) ? chain_t'{trail: rdata_q, bmax: bm_q}
                                              : chain_i;

endmodule

>>> rtl/band_onset_trail_scroller_core.sv
// top level of the band onset trail scroller: sequencer, divider and cell row
//
// channel | signals                       | word
// --------+-------------------------------+-----------------------------------
// in      | in_valid_i / in_stall_o       | mode, column, amplitude, elapsed_ms, row
// out     | out_valid_o / out_stall_i     | trail_value, brightness, palette_index
// cfg     | cfg_we_i / cfg_wdata_i        | band_count
//
// pixel read: one registered read of the column memories, then the registered output word
// band sample: multiply, max, 8 divider steps, cell update
// frame tick: one row walk per scroll step in every column cell
// after reset and on clear: a clearing pass over all rows of the column memories
// in_stall_o is high while busy and while a result waits under out_stall_i
module band_onset_trail_scroller_core #(
  parameter int unsigned COLUMNS = bost_pkg::ColumnsDef,
  parameter int unsigned ROWS    = bost_pkg::RowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  column_i,
  input  logic [15:0] amplitude_i,
  input  logic [15:0] elapsed_ms_i,
  input  logic [7:0]  row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  trail_value_o,
  output logic [7:0]  brightness_o,
  output logic [7:0]  palette_index_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);
  import bost_pkg::*;

  localparam int unsigned AW = $clog2(ROWS);
  localparam int unsigned KW = $clog2(ROWS + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CLR  = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_MAX  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_UPD  = 8'b0010_0000,
    S_SCRL = 8'b0100_0000,
    S_RD   = 8'b1000_0000
  } state_e;

  state_e      state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic [2:0]  steps_q, steps_d, cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d, raw_q, raw_d, m_q, m_d;
  logic [3:0]  band_count_q, col_q, col_d;
  logic        oor_q, oor_d;
  logic [31:0] prod_q, prod_d;
  logic [23:0] rem_q, rem_d, dsh_q, dsh_d;
  logic [7:0]  quo_q, quo_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  trail_q, trail_d, bright_q, bright_d, pal_q, pal_d;

  ctrl_t         ctrl;
  logic [AW-1:0] ra, wa;
  logic [5:0]    bands;
  logic          in_acc;
  chain_t        chain [COLUMNS+1];

  // tick arithmetic
  logic [6:0]  dtc;
  logic [16:0] sum;
  logic [15:0] sumc, dm, mx;
  logic [2:0]  st;
  logic [7:0]  v;

  always_comb begin
    bands = {2'b00, band_count_q};
    if (bands == 6'd0) bands = 6'd1;
    if (bands > 6'(COLUMNS)) bands = 6'(COLUMNS);
  end

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    dtc  = (elapsed_ms_i > 16'(DT_CLAMP)) ? DT_CLAMP : elapsed_ms_i[6:0];
    sum  = 17'(acc_q) + 17'(dtc);
    sumc = sum[16] ? 16'hFFFF : sum[15:0];
    st   = (sumc[15:4] >= 12'(MAX_STEPS)) ? MAX_STEPS : sumc[6:4];
    dm   = prod_q[31:16];
    mx   = (raw_q > dm) ? raw_q : dm;
    if (mx < MAX_FLOOR) mx = MAX_FLOOR;
    v    = oor_q ? 8'd0 : chain[COLUMNS].trail;
  end

  always_comb begin
    state_d = state_q; k_d = k_q; steps_d = steps_q; cnt_d = cnt_q;
    acc_d = acc_q; raw_d = raw_q; m_d = m_q; col_d = col_q; oor_d = oor_q;
    prod_d = prod_q; rem_d = rem_q; dsh_d = dsh_q; quo_d = quo_q;
    out_valid_d = out_valid_q; trail_d = trail_q; bright_d = bright_q; pal_d = pal_q;
    ctrl = '{re: 1'b0, we: 1'b0, wsrc: WS_ZERO, upd: 1'b0, clr: 1'b0, inj_clr: 1'b0};
    ra = AW'(row_i);
    wa = AW'(k_q);

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (mode_e'(mode_i))
            MODE_SAMPLE: begin
              if (int'(column_i) < int'(bands)) begin
                col_d = column_i; raw_d = amplitude_i; state_d = S_MUL;
              end
            end
            MODE_TICK: begin
              acc_d = sumc - {9'd0, st, 4'd0};
              if (st == 3'd0) begin
                ctrl.inj_clr = 1'b1;
              end else begin
                steps_d = st; k_d = '0; state_d = S_SCRL;
              end
            end
            MODE_READ: begin
              col_d   = column_i;
              oor_d   = (int'(column_i) >= int'(COLUMNS)) || (int'(row_i) >= int'(ROWS));
              ctrl.re = 1'b1;
              state_d = S_RD;
            end
            default: begin
              ctrl.clr = 1'b1; acc_d = '0; k_d = '0; state_d = S_CLR;
            end
          endcase
        end
      end
      S_CLR: begin
        ctrl.we = 1'b1;
        if (k_q == KW'(ROWS - 1)) state_d = S_IDLE;
        else k_d = k_q + KW'(1);
      end
      S_MUL: begin
        prod_d  = 32'(chain[COLUMNS].bmax) * 32'(MAX_DECAY);
        state_d = S_MAX;
      end
      S_MAX: begin
        m_d = mx; rem_d = 24'(raw_q) * 24'd255; dsh_d = 24'(mx) << 7;
        quo_d = '0; cnt_d = '0; state_d = S_DIV;
      end
      S_DIV: begin
        // one restoring quotient bit per cycle, msb first
        if (rem_q >= dsh_q) begin
          rem_d = rem_q - dsh_q; quo_d = {quo_q[6:0], 1'b1};
        end else begin
          quo_d = {quo_q[6:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) state_d = S_UPD;
      end
      S_UPD: begin
        ctrl.upd = 1'b1; state_d = S_IDLE;
      end
      S_SCRL: begin
        // read row k+1, write row k-1 from the previous read, top row last
        ra      = AW'(k_q + KW'(1));
        ctrl.re = (k_q < KW'(ROWS - 1));
        wa      = AW'(k_q - KW'(1));
        ctrl.we = (k_q != '0);
        ctrl.wsrc = (k_q == KW'(ROWS)) ? WS_INJ : WS_DECAY;
        if (k_q == KW'(ROWS)) begin
          k_d = '0;
          if (steps_q == 3'd1) begin
            ctrl.inj_clr = 1'b1; state_d = S_IDLE;
          end else begin
            steps_d = steps_q - 3'd1;
          end
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      S_RD: begin
        out_valid_d = 1'b1;
        trail_d  = v;
        bright_d = qadd8(v, 8'd6);
        pal_d    = qadd8(sc8(v, 8'd220), 8'd8);
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; k_q <= '0; steps_q <= '0; cnt_q <= '0; acc_q <= '0;
      band_count_q <= BAND_COUNT_RST; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; k_q <= k_d; steps_q <= steps_d; cnt_q <= cnt_d;
      acc_q <= acc_d; out_valid_q <= out_valid_d;
      if (cfg_we_i) band_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d; m_q <= m_d; col_q <= col_d; oor_q <= oor_d; prod_q <= prod_d;
    rem_q <= rem_d; dsh_q <= dsh_d; quo_q <= quo_d;
    trail_q <= trail_d; bright_q <= bright_d; pal_q <= pal_d;
  end

  assign chain[0] = '0;

  for (genvar gi = 0; gi < COLUMNS; gi++) begin : g_cell
    bost_cell #(
      .IDX (gi),
      .ROWS(ROWS),
      .AW  (AW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .sel_i  (col_q),
      .ra_i   (ra),
      .wa_i   (wa),
      .norm_i (quo_q),
      .m_i    (m_q),
      .bands_i(bands),
      .chain_i(chain[gi]),
      .chain_o(chain[gi+1])
    );
  end

  assign out_valid_o     = out_valid_q;
  assign trail_value_o   = trail_q;
  assign brightness_o    = bright_q;
  assign palette_index_o = pal_q;

`include "band_onset_trail_scroller_core_assert.svh"

`BOST_ASSERT_NEXT(a_read_gives_word, state_q == S_RD, out_valid_q)
`BOST_ASSERT_NOW(a_div_remainder, state_q == S_DIV, {1'b0, rem_q} < {dsh_q, 1'b0})
`BOST_ASSERT_NOW(a_step_count, state_q == S_SCRL, steps_q != 3'd0 && steps_q <= MAX_STEPS)
`BOST_ASSERT_NOW(a_row_walk, state_q == S_SCRL, k_q <= KW'(ROWS))

endmodule

>>> sim/testbench.sv
// self-checking testbench for the band onset trail scroller core
`timescale 1ns / 100ps

module testbench;
  import bost_pkg::*;

  localparam int NCOL = 12;
  localparam int NROW = 144;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  column;
    logic [15:0] amplitude;
    logic [15:0] elapsed_ms;
    logic [7:0]  row;
  } word_t;

  typedef struct packed {
    logic [7:0] trail;
    logic [7:0] bright;
    logic [7:0] pal;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [3:0]  column_i = '0;
  logic [15:0] amplitude_i = '0;
  logic [15:0] elapsed_ms_i = '0;
  logic [7:0]  row_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  trail_value_o;
  logic [7:0]  brightness_o;
  logic [7:0]  palette_index_o;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;

  band_onset_trail_scroller_core uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .column_i, .amplitude_i,
    .elapsed_ms_i, .row_i, .out_valid_o, .out_stall_i, .trail_value_o,
    .brightness_o, .palette_index_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predicted scroller state
  logic [7:0]  trail_mem [NCOL*NROW];
  logic [15:0] peak [NCOL];
  logic [7:0]  last_norm [NCOL];
  logic [7:0]  gate [NCOL];
  logic [1:0]  cooldown [NCOL];
  logic [7:0]  inject [NCOL];
  logic [15:0] accum;
  logic [3:0]  band_cnt;

  word_t  word_q[$];
  pixel_t pixel_q[$];
  int     errors = 0;
  bit     idle_on = 1'b1;
  bit     hold_rx = 1'b0;
  bit     took = 1'b0;

  function automatic int unsigned mul8(int unsigned v, int unsigned s);
    return ((v & 255) * ((s & 255) + 1)) >> 8;
  endfunction

  function automatic int unsigned sat8(int unsigned a);
    return a > 255 ? 255 : a;
  endfunction

  function automatic int unsigned live_bands();
    if (band_cnt < 1) return 1;
    if (band_cnt > NCOL) return NCOL;
    return 32'(band_cnt);
  endfunction

  task automatic wipe_state();
    foreach (trail_mem[i]) trail_mem[i] = '0;
    for (int i = 0; i < NCOL; i++) begin
      peak[i] = '0; last_norm[i] = '0; gate[i] = '0; cooldown[i] = '0; inject[i] = '0;
    end
    accum = '0;
  endtask

  task automatic predict_word(word_t w);
    int unsigned m, norm, g, b, amp, sum, steps, dt, v;
    pixel_t p;
    case (mode_e'(w.mode))
      MODE_SAMPLE: begin
        b = 32'(w.column);
        amp = 32'(w.amplitude);
        if (b < live_bands()) begin
          m = (peak[b] * 65208) >> 16;
          if (amp > m) m = amp;
          if (m < 128) m = 128;
          peak[b] = 16'(m);
          norm = (amp * 255) / m;
          if (norm > 255) norm = 255;
          if (cooldown[b] > 0) cooldown[b]--;
          g = 32'(gate[b]);
          if (cooldown[b] == 0 && norm > 140 && norm > last_norm[b] &&
              norm - last_norm[b] > 25) begin
            g = sat8(g + 170 + norm * 80 / 255);
            cooldown[b] = 2'd2;
          end
          last_norm[b] = 8'(norm);
          if (norm > 127) g = sat8(g + 6 + norm * 20 / 255);
          g = (norm > 102) ? (g > 2 ? g - 2 : 0) : (g > 10 ? g - 10 : 0);
          gate[b] = 8'(g);
          inject[b] = 8'((g > 0) ? sat8(norm + mul8(g, 40)) : 0);
        end
      end
      MODE_TICK: begin
        dt = (w.elapsed_ms > 16'd100) ? 100 : 32'(w.elapsed_ms);
        sum = accum + dt;
        if (sum > 65535) sum = 65535;
        steps = 0;
        while (sum >= 16 && steps < 6) begin
          sum -= 16;
          steps++;
        end
        accum = 16'(sum);
        for (int s = 0; s < steps; s++)
          for (int x = 0; x < NCOL; x++) begin
            for (int y = 0; y < NROW - 1; y++)
              trail_mem[x*NROW+y] = 8'(mul8(32'(trail_mem[x*NROW+y+1]), 246));
            trail_mem[x*NROW+NROW-1] = (x < live_bands()) ? inject[x] : 8'd0;
          end
        for (int x = 0; x < NCOL; x++) inject[x] = '0;
      end
      MODE_READ: begin
        v = (w.column < NCOL && w.row < NROW) ? 32'(trail_mem[w.column*NROW+w.row]) : 0;
        p.trail = 8'(v);
        p.bright = 8'(sat8(v + 6));
        p.pal = 8'(sat8(mul8(v, 220) + 8));
        pixel_q.push_back(p);
      end
      default: wipe_state();
    endcase
  endtask

  // acceptance is seen at the rising edge, prediction follows it there
  always @(posedge clk_i) begin
    took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_word(word_q.pop_front());
    end
  end

  // driver: presents queued words at the falling edge
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !took) begin
        // hold the stalled word
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        send_gap <= int'($urandom_range(0, 13));
        in_valid_i <= 1'b0;
      end else if (word_q.size() > 0) begin
        in_valid_i <= 1'b1;
        {mode_i, column_i, amplitude_i, elapsed_ms_i, row_i} <= word_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall
  int stall_gap = 0;
  always @(negedge clk_i) begin
    if (hold_rx) out_stall_i <= 1'b1;
    else if (stall_gap > 0) begin
      stall_gap <= stall_gap - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_gap <= int'($urandom_range(0, 13));
      out_stall_i <= 1'b1;
    end else out_stall_i <= 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %0d %0d %0d",
                                   trail_value_o, brightness_o, palette_index_o);
      end else begin
        pixel_t e;
        e = pixel_q.pop_front();
        if (e.trail !== trail_value_o || e.bright !== brightness_o ||
            e.pal !== palette_index_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d %0d %0d got %0d %0d %0d", e.trail, e.bright,
                     e.pal, trail_value_o, brightness_o, palette_index_o);
        end
      end
    end
  end

  function automatic word_t mk(mode_e md, int c, int a, int el, int r);
    word_t w;
    w.mode = md; w.column = 4'(c); w.amplitude = 16'(a); w.elapsed_ms = 16'(el);
    w.row = 8'(r);
    return w;
  endfunction

  function automatic word_t rand_word();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return mk(MODE_SAMPLE, $urandom_range(0, 15),
                          ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1024),
                          $urandom, $urandom);
    if (k < 60) return mk(MODE_TICK, $urandom, $urandom, ($urandom_range(0, 7) == 0) ?
                          $urandom : $urandom_range(0, 110), $urandom);
    if (k < 99) return mk(MODE_READ, ($urandom_range(0, 15) == 0) ? $urandom :
                          $urandom_range(0, 11), $urandom,
                          $urandom, ($urandom_range(0, 15) == 0) ? $urandom :
                          ($urandom_range(0, 1) ? $urandom_range(128, 143) :
                           $urandom_range(0, 143)));
    return mk(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic drain();
    while (word_q.size() > 0 || in_valid_i || pixel_q.size() > 0) @(posedge clk_i);
    repeat (6 * 145 + 40) @(posedge clk_i);
  endtask

  task automatic write_count(int v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 4'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    band_cnt = 4'(v);
  endtask

  int counts[6] = '{12, 0, 1, 15, 5, 12};

  initial begin
    band_cnt = BAND_COUNT_RST;
    wipe_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (NROW + 10) @(posedge clk_i);

    // directed part
    word_q.push_back(mk(MODE_SAMPLE, 0, 16'hFFFF, 0, 0));
    word_q.push_back(mk(MODE_SAMPLE, 0, 0, 16'hFFFF, 8'hFF));
    word_q.push_back(mk(MODE_SAMPLE, 1, 50, 0, 0));
    for (int i = 0; i < 4; i++) word_q.push_back(mk(MODE_SAMPLE, 2, 20 + 300 * i, 0, 0));
    word_q.push_back(mk(MODE_SAMPLE, 15, 1000, 0, 0));
    word_q.push_back(mk(MODE_TICK, 0, 0, 16'hFFFF, 0));
    word_q.push_back(mk(MODE_TICK, 0, 0, 0, 0));
    word_q.push_back(mk(MODE_TICK, 0, 0, 15, 0));
    word_q.push_back(mk(MODE_READ, 0, 0, 0, 143));
    word_q.push_back(mk(MODE_READ, 2, 0, 0, 142));
    word_q.push_back(mk(MODE_READ, 11, 0, 0, 0));
    word_q.push_back(mk(MODE_READ, 12, 0, 0, 5));
    word_q.push_back(mk(MODE_READ, 15, 0, 0, 143));
    word_q.push_back(mk(MODE_READ, 0, 0, 0, 144));
    word_q.push_back(mk(MODE_READ, 0, 0, 0, 255));
    word_q.push_back(mk(MODE_CLEAR, 0, 0, 0, 0));
    word_q.push_back(mk(MODE_READ, 0, 0, 0, 143));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_count(counts[ph]);
      if (ph == 5) idle_on = 1'b0;
      for (int i = 0; i < 200; i++) word_q.push_back(rand_word());
      if (ph == 1) begin
        // long receiver hold while the sender keeps offering
        hold_rx = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      drain();
    end
    if (errors == 0) $display("band_onset_trail_scroller_core verification clean");
    else $display("band_onset_trail_scroller_core verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("band_onset_trail_scroller_core verification failed");
    $finish;
  end
endmodule
